>>> design/glsa_pkg.sv
// ----------------------------------------------------------------------------
// glsa_pkg
// shared constants, codes and types of the grouped leaf slot allocator
// ----------------------------------------------------------------------------
package glsa_pkg;

  // geometry
  localparam int LEAVES_PER_GROUP = 16;
  localparam int MAX_GROUPS       = 64;
  localparam int STACK_DEPTH      = MAX_GROUPS * LEAVES_PER_GROUP;

  // internal widths
  localparam int LEAF_W = $clog2(LEAVES_PER_GROUP);
  localparam int GRP_W  = $clog2(MAX_GROUPS);
  localparam int CODE_W = $clog2(STACK_DEPTH);

  // field widths
  localparam int CMD_W        = 2;
  localparam int GROUP_ID_W   = 7;
  localparam int LEAF_ID_W    = 4;
  localparam int STATUS_W     = 2;
  localparam int CNT_W        = 5;
  localparam int FREE_LEFT_W  = 11;
  localparam int IN_FIELDS_W  = CMD_W + GROUP_ID_W + LEAF_ID_W;
  localparam int OUT_FIELDS_W = STATUS_W + GROUP_ID_W + LEAF_ID_W + 1 + 1 + CNT_W
                                + FREE_LEFT_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_OPEN,
    S_LOOKUP,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic stack_rd;
    logic grp_rd;
    logic sweep_wr;
    logic exec;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic stack_empty;
    logic no_space;
    logic sweep_last;
    logic out_busy;
  } stat_t;

  // free stack entry
  typedef struct packed {
    logic [GRP_W-1:0]  gi;
    logic [LEAF_W-1:0] leaf;
  } slot_t;

  // per-group bookkeeping word
  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [LEAVES_PER_GROUP-1:0] bits;
  } grp_entry_t;

endpackage

>>> design/glsa_ctrl.sv
// ----------------------------------------------------------------------------
// glsa_ctrl
// sequencer for fetch, group open sweep, lookup and execute
// ----------------------------------------------------------------------------
module glsa_ctrl import glsa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        ctrl.stack_rd = 1'b1;
        if (stat.is_alloc && stat.stack_empty) begin
          state_next = stat.no_space ? S_EXEC : S_OPEN;
        end else begin
          state_next = S_LOOKUP;
        end
      end
      S_OPEN: begin
        ctrl.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_EXEC;
        end
      end
      S_LOOKUP: begin
        ctrl.grp_rd = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          ctrl.exec  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/glsa_datapath.sv
// ----------------------------------------------------------------------------
// glsa_datapath
// free stack, group bitmap memory, counters and result register
// ----------------------------------------------------------------------------
module glsa_datapath import glsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  ctrl_t                 ctrl,
  output stat_t                 stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data
);

  // memories
  slot_t      stack_mem [STACK_DEPTH];
  grp_entry_t grp_mem   [MAX_GROUPS];

  // item and state registers
  logic [CMD_W-1:0]       cmd_q;
  logic [GROUP_ID_W-1:0]  g_q;
  logic [LEAF_ID_W-1:0]   leaf_q;
  logic [FREE_LEFT_W-1:0] free_count;
  logic [GROUP_ID_W-1:0]  next_group;
  logic [LEAF_W-1:0]      sweep_cnt;
  slot_t                  stack_rd;
  grp_entry_t             grp_rd;

  // execute results
  logic [FREE_LEFT_W-1:0] free_count_next;
  logic [GROUP_ID_W-1:0]  next_group_next;
  logic                   grp_we;
  logic [GRP_W-1:0]       grp_wa;
  grp_entry_t             grp_wd;
  logic                   push_en;
  slot_t                  push_slot;
  logic [STATUS_W-1:0]    r_status;
  logic [GROUP_ID_W-1:0]  r_group;
  logic [LEAF_ID_W-1:0]   r_leaf;
  logic                   r_exists;
  logic                   r_used;
  logic [CNT_W-1:0]       r_cnt;
  logic                   r_opened;

  logic                   ex;
  logic [GRP_W-1:0]       q_gi;
  logic                   q_used;
  logic [CNT_W-1:0]       q_cnt;
  logic [GRP_W-1:0]       open_gi;
  logic [LEAF_W-1:0]      top_leaf;

  assign stat.is_alloc    = (cmd_q == CMD_ALLOC);
  assign stat.stack_empty = (free_count == '0);
  assign stat.no_space    = (32'(next_group) > MAX_GROUPS);
  assign stat.sweep_last  = (sweep_cnt == LEAF_W'(LEAVES_PER_GROUP - 1));
  assign stat.out_busy    = out_valid && !out_ready;

  assign q_gi     = GRP_W'(g_q - GROUP_ID_W'(1));
  assign open_gi  = GRP_W'(next_group - GROUP_ID_W'(1));
  assign top_leaf = LEAF_W'(LEAVES_PER_GROUP - 1);
  assign ex       = (g_q != '0) && (g_q < next_group) && (32'(g_q) <= MAX_GROUPS)
                    && (32'(leaf_q) < LEAVES_PER_GROUP);
  assign q_used   = ex && grp_rd.bits[LEAF_W'(leaf_q)];
  assign q_cnt    = ex ? grp_rd.cnt : '0;

  always_comb begin
    free_count_next = free_count;
    next_group_next = next_group;
    grp_we          = 1'b0;
    grp_wa          = q_gi;
    grp_wd          = grp_rd;
    push_en         = 1'b0;
    push_slot.gi    = q_gi;
    push_slot.leaf  = LEAF_W'(leaf_q);
    r_status        = ST_OK;
    r_group         = g_q;
    r_leaf          = leaf_q;
    r_exists        = ex;
    r_used          = q_used;
    r_cnt           = q_cnt;
    r_opened        = 1'b0;
    case (cmd_q)
      CMD_ALLOC: begin
        r_exists = 1'b1;
        r_used   = 1'b1;
        if (free_count == '0) begin
          if (stat.no_space) begin
            r_status = ST_NO_SPACE;
            r_group  = '0;
            r_leaf   = '0;
            r_exists = 1'b0;
            r_used   = 1'b0;
            r_cnt    = '0;
          end else begin
            // fresh group: its top leaf is handed out right away
            grp_we          = 1'b1;
            grp_wa          = open_gi;
            grp_wd.bits     = '0;
            grp_wd.bits[top_leaf] = 1'b1;
            grp_wd.cnt      = CNT_W'(1);
            free_count_next = FREE_LEFT_W'(LEAVES_PER_GROUP - 1);
            next_group_next = next_group + GROUP_ID_W'(1);
            r_group         = next_group;
            r_leaf          = LEAF_ID_W'(top_leaf);
            r_cnt           = CNT_W'(1);
            r_opened        = 1'b1;
          end
        end else begin
          grp_we          = 1'b1;
          grp_wa          = stack_rd.gi;
          grp_wd.bits[stack_rd.leaf] = 1'b1;
          grp_wd.cnt      = grp_rd.cnt + CNT_W'(1);
          free_count_next = free_count - FREE_LEFT_W'(1);
          r_group         = GROUP_ID_W'(stack_rd.gi) + GROUP_ID_W'(1);
          r_leaf          = LEAF_ID_W'(stack_rd.leaf);
          r_cnt           = grp_rd.cnt + CNT_W'(1);
        end
      end
      CMD_FREE: begin
        if (!q_used) begin
          r_status = ST_REJECT;
        end else begin
          grp_we = 1'b1;
          grp_wd.bits[LEAF_W'(leaf_q)] = 1'b0;
          if (grp_rd.cnt != '0) begin
            grp_wd.cnt = grp_rd.cnt - CNT_W'(1);
          end
          if (32'(free_count) < STACK_DEPTH) begin
            push_en         = 1'b1;
            free_count_next = free_count + FREE_LEFT_W'(1);
          end
          r_used = 1'b0;
          r_cnt  = grp_wd.cnt;
        end
      end
      default: begin
        // query, and the unused code behaves the same
      end
    endcase
  end

  // free stack: one write port, registered read of the top entry
  always_ff @(posedge clk) begin
    if (ctrl.sweep_wr) begin
      stack_mem[CODE_W'(sweep_cnt)] <= '{gi: open_gi, leaf: sweep_cnt};
    end else if (ctrl.exec && push_en) begin
      stack_mem[free_count[CODE_W-1:0]] <= push_slot;
    end
    if (ctrl.stack_rd) begin
      stack_rd <= stack_mem[CODE_W'(free_count - FREE_LEFT_W'(1))];
    end
  end

  // group bitmap and counts
  always_ff @(posedge clk) begin
    if (ctrl.exec && grp_we) begin
      grp_mem[grp_wa] <= grp_wd;
    end
    if (ctrl.grp_rd) begin
      grp_rd <= grp_mem[stat.is_alloc ? stack_rd.gi : q_gi];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= in_data[CMD_W-1:0];
      g_q    <= in_data[CMD_W +: GROUP_ID_W];
      leaf_q <= in_data[CMD_W+GROUP_ID_W +: LEAF_ID_W];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      next_group <= GROUP_ID_W'(1);
      sweep_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.load) begin
        sweep_cnt <= '0;
      end else if (ctrl.sweep_wr) begin
        sweep_cnt <= sweep_cnt + LEAF_W'(1);
      end
      if (ctrl.exec) begin
        free_count <= free_count_next;
        next_group <= next_group_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_data <= OUT_DATA_W'({r_opened, free_count_next, r_cnt, r_used, r_exists,
                               r_leaf, r_group, r_status});
    end
  end

endmodule

>>> design/grouped_leaf_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// grouped_leaf_slot_allocator_top
// lifo free-stack slot allocator with per-group used bitmap
// ----------------------------------------------------------------------------
// sequence: fetch, lookup, then execute registers the result; an allocate
//   on an empty stack skips lookup, and if a group is left goes through
//   open, which sweeps its 16 leaves onto the stack one per cycle through
//   the single write port; one item in flight, stalled by an untaken result
// reset (rst, synchronous): stack empty, next group 1, no group opened;
//   memories are not cleared, a group's bitmap word is written when it opens
// ----------------------------------------------------------------------------
module grouped_leaf_slot_allocator_top import glsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] command, [8:2] group_id, [12:9] leaf_index, [15:13] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [8:2] slot_group, [12:9] slot_leaf, [13] leaf_exists,
  // [14] leaf_used, [19:15] group_used_count, [30:20] free_left,
  // [31] opened_group
  output logic [OUT_DATA_W-1:0] m_tdata
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: one item in flight, the result register frees it to take
  // the next transfer while a result still waits
  glsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // storage and arithmetic
  glsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
